// ===== hw/rtl/gre_pkg.sv =====
// Shared constants, codes and helper functions of the glyph row expander.
`default_nettype none

package gre_pkg;

   // Glyph geometry.
   localparam int GLYPH_ROWS  = 16;
   localparam int GLYPH_COLS  = 8;
   localparam int GLYPH_COUNT = 256;

   // Fixed field widths.
   localparam int ADDR_W   = 48;
   localparam int COLOR_W  = 32;
   localparam int SCREEN_W = 13;
   localparam int PITCH_W  = 16;
   localparam int BPP_W    = 6;
   localparam int CODE_IN_W = 8;
   localparam int FROW_W   = 4;
   localparam int FBITS_W  = 8;
   localparam int COL_W    = 10;
   localparam int CROW_W   = 9;

   // Only this depth produces writes.
   localparam logic [BPP_W-1:0] FULL_DEPTH = BPP_W'(32);
   localparam int PIX_BYTES = 4;

   // Derived widths.
   localparam int ROW_W    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam int CODE_W   = $clog2(GLYPH_COUNT);
   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW  = $clog2(FONT_DEPTH);
   localparam int PY_W     = $clog2((1 << CROW_W) * GLYPH_ROWS);
   localparam int PX_W     = SCREEN_W;
   localparam int YC_W     = (PY_W > SCREEN_W) ? PY_W : SCREEN_W;
   localparam int PROD_W   = PY_W + PITCH_W;

   // Request type codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   // Register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_PER_PIXEL = 3'd4;

   // Fold a glyph code into the store; codes stay below twice the glyph count.
   function automatic logic [CODE_W-1:0] wrap_code(input logic [CODE_IN_W-1:0] code);
      logic [CODE_IN_W:0] ext;
      logic [CODE_IN_W:0] lim;
      ext = {1'b0, code};
      lim = (CODE_IN_W+1)'(GLYPH_COUNT);
      if (ext >= lim) begin
         ext = ext - lim;
      end
      return ext[CODE_W-1:0];
   endfunction

   // First store entry of a glyph.
   function automatic logic [FONT_AW-1:0] glyph_base(input logic [CODE_IN_W-1:0] code);
      return FONT_AW'(wrap_code(code)) * FONT_AW'(GLYPH_ROWS);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/glyph_row_expander_core.sv =====
// Character generator: font store, address sequencer and row result register.
// A draw transaction is accepted in idle; the first row result is registered after the
// S_OFFS and S_ADDR states, and one row follows per cycle while the result side takes them.
// A draw keeps req_stall high until its last row is loaded; a load does not leave idle.
// Rate is set by the single font read port and the one shared 48-bit address adder.
// Reset returns control and the configuration registers to their reset values; the font
// store is not cleared and holds garbage until loaded.
`default_nettype none

module glyph_row_expander_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [gre_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [gre_pkg::ADDR_W-1:0]           csr_wdata,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_type,
   input  wire logic [gre_pkg::CODE_IN_W-1:0]        req_glyph_code,
   input  wire logic [gre_pkg::FROW_W-1:0]           req_font_row,
   input  wire logic [gre_pkg::FBITS_W-1:0]          req_font_bits,
   input  wire logic [gre_pkg::COL_W-1:0]            req_cell_column,
   input  wire logic [gre_pkg::CROW_W-1:0]           req_cell_row,
   input  wire logic [gre_pkg::COLOR_W-1:0]          req_fg_color,
   input  wire logic [gre_pkg::COLOR_W-1:0]          req_bg_color,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [gre_pkg::ADDR_W-1:0]                rsp_row_address,
   output logic [gre_pkg::GLYPH_COLS-1:0]            rsp_write_mask,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_0,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_1,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_2,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_3,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_4,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_5,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_6,
   output logic [gre_pkg::COLOR_W-1:0]               rsp_pixel_7,
   output logic                                      rsp_last_row
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_OFFS = 2'd1;
   localparam logic [1:0] S_ADDR = 2'd2;
   localparam logic [1:0] S_ROWS = 2'd3;

   localparam logic [gre_pkg::ROW_W-1:0] LAST_ROW = gre_pkg::ROW_W'(gre_pkg::GLYPH_ROWS - 1);

   // configuration registers
   logic [gre_pkg::ADDR_W-1:0]   frame_base_ff;
   logic [gre_pkg::SCREEN_W-1:0] screen_width_ff;
   logic [gre_pkg::SCREEN_W-1:0] screen_height_ff;
   logic [gre_pkg::PITCH_W-1:0]  line_pitch_ff;
   logic [gre_pkg::BPP_W-1:0]    bits_per_pixel_ff;

   // sequencer
   logic [1:0] state_ff, state_in;
   logic [gre_pkg::ROW_W-1:0] row_ff, row_in;

   // item registers
   logic [gre_pkg::FONT_AW-1:0]  gbase_ff;
   logic [gre_pkg::COL_W-1:0]    col_ff;
   logic [gre_pkg::PY_W-1:0]     py_ff, py_in;
   logic [gre_pkg::COLOR_W-1:0]  fg_ff, bg_ff;
   logic [gre_pkg::PROD_W-1:0]   prod_ff;
   logic [gre_pkg::GLYPH_COLS-1:0] colmask_ff, colmask_in;
   logic [gre_pkg::ADDR_W-1:0]   acc_ff, acc_in;

   // shared adder
   logic [gre_pkg::ADDR_W-1:0]   add_a, add_b, add_sum;

   // font store
   logic [gre_pkg::FBITS_W-1:0]  font_mem [gre_pkg::FONT_DEPTH];
   logic [gre_pkg::FBITS_W-1:0]  rd_ff;
   logic [gre_pkg::FONT_AW-1:0]  rd_addr, wr_addr;
   logic                         wr_en;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gre_pkg::ADDR_W-1:0]   addr_out_ff;
   logic [gre_pkg::GLYPH_COLS-1:0] mask_out_ff, mask_out_in;
   logic [gre_pkg::COLOR_W-1:0]  pix_ff [gre_pkg::GLYPH_COLS];
   logic                         last_ff;

   logic req_acc;
   logic out_free;
   logic out_load;
   logic [gre_pkg::PX_W-1:0] px;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == S_ROWS) && out_free;
   assign px        = gre_pkg::PX_W'(col_ff) * gre_pkg::PX_W'(gre_pkg::GLYPH_COLS);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff     <= '0;
         screen_width_ff   <= '0;
         screen_height_ff  <= '0;
         line_pitch_ff     <= '0;
         bits_per_pixel_ff <= gre_pkg::FULL_DEPTH;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gre_pkg::CSR_FRAME_BASE:     frame_base_ff     <= csr_wdata;
            gre_pkg::CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_wdata[gre_pkg::SCREEN_W-1:0];
            gre_pkg::CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_wdata[gre_pkg::SCREEN_W-1:0];
            gre_pkg::CSR_LINE_PITCH:     line_pitch_ff     <= csr_wdata[gre_pkg::PITCH_W-1:0];
            gre_pkg::CSR_BITS_PER_PIXEL: bits_per_pixel_ff <= csr_wdata[gre_pkg::BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // shared adder: seed offset, add row product, then step by the pitch
   always_comb begin
      add_a = (state_ff == S_OFFS) ? frame_base_ff : acc_ff;
      unique case (state_ff)
         S_OFFS:  add_b = gre_pkg::ADDR_W'(px) * gre_pkg::ADDR_W'(gre_pkg::PIX_BYTES);
         S_ADDR:  add_b = gre_pkg::ADDR_W'(prod_ff);
         default: add_b = gre_pkg::ADDR_W'(line_pitch_ff);
      endcase
      add_sum = add_a + add_b;
   end

   always_comb begin
      for (int j = 0; j < gre_pkg::GLYPH_COLS; j++) begin
         colmask_in[j] = ({1'b0, px} + (gre_pkg::PX_W+1)'(j)) < {1'b0, screen_width_ff};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = '0;
      acc_in   = acc_ff;
      py_in    = py_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_type == gre_pkg::REQ_DRAW) begin
               state_in = S_OFFS;
               py_in    = gre_pkg::PY_W'(req_cell_row) * gre_pkg::PY_W'(gre_pkg::GLYPH_ROWS);
            end
         end
         S_OFFS: begin
            acc_in   = add_sum;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            acc_in   = add_sum;
            state_in = S_ROWS;
         end
         S_ROWS: begin
            row_in = row_ff;
            if (out_free) begin
               acc_in = add_sum;
               py_in  = py_ff + gre_pkg::PY_W'(1);
               if (row_ff == LAST_ROW) begin
                  row_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  row_in = row_ff + gre_pkg::ROW_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      py_ff  <= py_in;
      if (req_acc) begin
         gbase_ff <= gre_pkg::glyph_base(req_glyph_code);
         col_ff   <= req_cell_column;
         fg_ff    <= req_fg_color;
         bg_ff    <= req_bg_color;
      end
      if (state_ff == S_OFFS) begin
         prod_ff    <= gre_pkg::PROD_W'(py_ff) * gre_pkg::PROD_W'(line_pitch_ff);
         colmask_ff <= colmask_in;
      end
   end

   // font store: one write port for loads, one registered read following the row
   assign wr_en   = req_acc && req_type == gre_pkg::REQ_LOAD &&
                    int'(req_font_row) < gre_pkg::GLYPH_ROWS;
   assign wr_addr = gre_pkg::glyph_base(req_glyph_code) + gre_pkg::FONT_AW'(req_font_row);
   assign rd_addr = gbase_ff + gre_pkg::FONT_AW'(row_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         font_mem[wr_addr] <= req_font_bits;
      end
      rd_ff <= font_mem[rd_addr];
   end

   // result register
   always_comb begin
      mask_out_in = '0;
      if (gre_pkg::YC_W'(py_ff) < gre_pkg::YC_W'(screen_height_ff) &&
          bits_per_pixel_ff == gre_pkg::FULL_DEPTH) begin
         mask_out_in = colmask_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         addr_out_ff <= acc_ff;
         mask_out_ff <= mask_out_in;
         last_ff     <= (row_ff == LAST_ROW);
         for (int j = 0; j < gre_pkg::GLYPH_COLS; j++) begin
            pix_ff[j] <= rd_ff[gre_pkg::GLYPH_COLS-1-j] ? fg_ff : bg_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_address = addr_out_ff;
   assign rsp_write_mask  = mask_out_ff;
   assign rsp_pixel_0     = pix_ff[0];
   assign rsp_pixel_1     = pix_ff[1];
   assign rsp_pixel_2     = pix_ff[2];
   assign rsp_pixel_3     = pix_ff[3];
   assign rsp_pixel_4     = pix_ff[4];
   assign rsp_pixel_5     = pix_ff[5];
   assign rsp_pixel_6     = pix_ff[6];
   assign rsp_pixel_7     = pix_ff[7];
   assign rsp_last_row    = last_ff;

   // a draw transaction starts the address sequence in the next cycle
   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_type == gre_pkg::REQ_DRAW |=> state_ff == S_OFFS)
      else $error("draw transaction did not start the sequencer");

   // consecutive row addresses differ by the line pitch
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      out_load && row_ff != LAST_ROW |=>
         (acc_ff - $past(acc_ff)) == gre_pkg::ADDR_W'(line_pitch_ff))
      else $error("row address did not advance by the pitch");

   // a result only appears while rows are being produced
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_ROWS)
      else $error("result raised outside the row phase");

endmodule

`default_nettype wire

// ===== tb/sv/tb_glyph_row_expander_core.sv =====
// Self-checking testbench for the glyph row expander core: font loads, glyph draws, clipping.
module tb_glyph_row_expander_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HOLD_OFF_CYCLES = 120;
   localparam int          QUIET_CYCLES    = 6;
   localparam int          TAIL_CYCLES     = 25;
   localparam int          STILL_LIMIT     = 1000;
   localparam int          PHASE_ITEMS     = 80;
   localparam logic [15:0][7:0] ROW_ART = {
      8'h99, 8'h24, 8'h42, 8'h81, 8'hC3, 8'h7E, 8'h3C, 8'h18,
      8'hF0, 8'h0F, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFF, 8'h00};

   typedef struct packed {
      logic                                kind;
      logic [gre_pkg::CODE_IN_W-1:0]       code;
      logic [gre_pkg::FROW_W-1:0]          frow;
      logic [gre_pkg::FBITS_W-1:0]         fbits;
      logic [gre_pkg::COL_W-1:0]           col;
      logic [gre_pkg::CROW_W-1:0]          crow;
      logic [gre_pkg::COLOR_W-1:0]         fg;
      logic [gre_pkg::COLOR_W-1:0]         bg;
   } glyph_req_type;

   typedef struct packed {
      logic [gre_pkg::ADDR_W-1:0]                                  addr;
      logic [gre_pkg::GLYPH_COLS-1:0]                              mask;
      logic [gre_pkg::GLYPH_COLS-1:0][gre_pkg::COLOR_W-1:0]        pix;
      logic                                                        last;
   } glyph_row_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_BURSTY} sink_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [gre_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gre_pkg::ADDR_W-1:0]     csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_type = gre_pkg::REQ_LOAD;
   logic [gre_pkg::CODE_IN_W-1:0]  req_glyph_code = '0;
   logic [gre_pkg::FROW_W-1:0]     req_font_row = '0;
   logic [gre_pkg::FBITS_W-1:0]    req_font_bits = '0;
   logic [gre_pkg::COL_W-1:0]      req_cell_column = '0;
   logic [gre_pkg::CROW_W-1:0]     req_cell_row = '0;
   logic [gre_pkg::COLOR_W-1:0]    req_fg_color = '0;
   logic [gre_pkg::COLOR_W-1:0]    req_bg_color = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [gre_pkg::ADDR_W-1:0]     rsp_row_address;
   logic [gre_pkg::GLYPH_COLS-1:0] rsp_write_mask;
   logic [gre_pkg::COLOR_W-1:0]    rsp_pixel_0, rsp_pixel_1, rsp_pixel_2, rsp_pixel_3;
   logic [gre_pkg::COLOR_W-1:0]    rsp_pixel_4, rsp_pixel_5, rsp_pixel_6, rsp_pixel_7;
   logic                           rsp_last_row;

   // Local copy of the font and of the registers
   logic [gre_pkg::FBITS_W-1:0]    font_copy [gre_pkg::FONT_DEPTH];
   logic [gre_pkg::GLYPH_ROWS-1:0] rows_loaded [gre_pkg::GLYPH_COUNT];
   bit                             glyph_ready [gre_pkg::GLYPH_COUNT];
   logic [gre_pkg::CODE_IN_W-1:0]  ready_glyphs [$];
   logic [gre_pkg::ADDR_W-1:0]     cfg_frame_base = '0;
   logic [gre_pkg::SCREEN_W-1:0]   cfg_screen_width = '0;
   logic [gre_pkg::SCREEN_W-1:0]   cfg_screen_height = '0;
   logic [gre_pkg::PITCH_W-1:0]    cfg_line_pitch = '0;
   logic [gre_pkg::BPP_W-1:0]      cfg_bits_per_pixel = gre_pkg::FULL_DEPTH;

   glyph_row_type         glyph_rows_due [$];
   int unsigned           bad_fields = 0;
   int unsigned           rows_seen = 0;
   int unsigned           burst_left = 0;
   bit                    gaps_on = 1'b1;
   bit                    hold_off_pending = 1'b0;
   sink_mode_type         sink_mode = SINK_CHOPPY;

   glyph_row_expander_core DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_glyph_code  (req_glyph_code),
      .req_font_row    (req_font_row),
      .req_font_bits   (req_font_bits),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_address (rsp_row_address),
      .rsp_write_mask  (rsp_write_mask),
      .rsp_pixel_0     (rsp_pixel_0),
      .rsp_pixel_1     (rsp_pixel_1),
      .rsp_pixel_2     (rsp_pixel_2),
      .rsp_pixel_3     (rsp_pixel_3),
      .rsp_pixel_4     (rsp_pixel_4),
      .rsp_pixel_5     (rsp_pixel_5),
      .rsp_pixel_6     (rsp_pixel_6),
      .rsp_pixel_7     (rsp_pixel_7),
      .rsp_last_row    (rsp_last_row)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string field, input int unsigned index,
                                  input logic [63:0] got, input logic [63:0] want);
      bad_fields++;
      $display("row result %0d: %s got %h want %h", index, field, got, want);
   endtask

   // Apply one accepted transaction to the local font and queue the rows it draws
   task automatic render_request(input glyph_req_type r);
      glyph_row_type               row;
      logic [63:0]                 px;
      logic [63:0]                 py;
      logic [63:0]                 addr;
      logic [gre_pkg::FBITS_W-1:0] bits;
      if (r.kind == gre_pkg::REQ_LOAD) begin
         font_copy[{r.code, r.frow}] = r.fbits;
         rows_loaded[r.code][r.frow] = 1'b1;
         if (rows_loaded[r.code] == '1 && !glyph_ready[r.code]) begin
            glyph_ready[r.code] = 1'b1;
            ready_glyphs.push_back(r.code);
         end
      end else begin
         px = 64'(r.col) * gre_pkg::GLYPH_COLS;
         for (int i = 0; i < gre_pkg::GLYPH_ROWS; i++) begin
            py = 64'(r.crow) * gre_pkg::GLYPH_ROWS + 64'(i);
            bits = font_copy[{r.code, gre_pkg::FROW_W'(i)}];
            addr = 64'(cfg_frame_base) + py * 64'(cfg_line_pitch) + px * gre_pkg::PIX_BYTES;
            row.addr = addr[gre_pkg::ADDR_W-1:0];
            row.mask = '0;
            for (int j = 0; j < gre_pkg::GLYPH_COLS; j++) begin
               row.pix[j] = bits[gre_pkg::GLYPH_COLS-1-j] ? r.fg : r.bg;
               if (px + 64'(j) < 64'(cfg_screen_width) && py < 64'(cfg_screen_height)) begin
                  row.mask[j] = 1'b1;
               end
            end
            if (cfg_bits_per_pixel != gre_pkg::FULL_DEPTH) begin
               row.mask = '0;
            end
            row.last = (i == gre_pkg::GLYPH_ROWS - 1);
            glyph_rows_due.push_back(row);
         end
      end
   endtask

   // Close a burst now and then and hold valid low for a while
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!gaps_on) begin
            gap = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            gap = $urandom_range(10, 30);
         end else begin
            gap = $urandom_range(1, 5);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input glyph_req_type r);
      req_valid       <= 1'b1;
      req_type        <= r.kind;
      req_glyph_code  <= r.code;
      req_font_row    <= r.frow;
      req_font_bits   <= r.fbits;
      req_cell_column <= r.col;
      req_cell_row    <= r.crow;
      req_fg_color    <= r.fg;
      req_bg_color    <= r.bg;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      render_request(r);
      pace();
   endtask

   function automatic glyph_req_type noisy_request();
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      return noise[$bits(glyph_req_type)-1:0];
   endfunction

   // Write all 16 rows of a glyph; random content goes in a scrambled row order
   task automatic load_glyph(input logic [gre_pkg::CODE_IN_W-1:0] code, input bit directed);
      glyph_req_type r;
      int unsigned   start;
      int unsigned   step;
      start = directed ? 0 : $urandom_range(0, gre_pkg::GLYPH_ROWS - 1);
      step  = directed ? 1 : 2 * $urandom_range(0, gre_pkg::GLYPH_ROWS / 2 - 1) + 1;
      for (int k = 0; k < gre_pkg::GLYPH_ROWS; k++) begin
         r = noisy_request();
         r.kind = gre_pkg::REQ_LOAD;
         r.code = code;
         r.frow = gre_pkg::FROW_W'(start + k * step);
         if (directed) begin
            r.fbits = ROW_ART[r.frow];
         end
         send_item(r);
      end
   endtask

   task automatic draw_at(input logic [gre_pkg::CODE_IN_W-1:0] code, input int col,
                          input int crow, input logic [gre_pkg::COLOR_W-1:0] fg,
                          input logic [gre_pkg::COLOR_W-1:0] bg);
      glyph_req_type r;
      r = noisy_request();
      r.kind = gre_pkg::REQ_DRAW;
      r.code = code;
      r.col  = gre_pkg::COL_W'(col);
      r.crow = gre_pkg::CROW_W'(crow);
      r.fg   = fg;
      r.bg   = bg;
      send_item(r);
   endtask

   // Half the draws sit on the clipping edges of the current screen
   task automatic draw_random();
      glyph_req_type r;
      r = noisy_request();
      r.kind = gre_pkg::REQ_DRAW;
      r.code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
      if ($urandom_range(0, 1) == 1) begin
         r.col  = gre_pkg::COL_W'(int'(cfg_screen_width / gre_pkg::GLYPH_COLS) +
                                  int'($urandom_range(0, 2)) - 1);
         r.crow = gre_pkg::CROW_W'(int'(cfg_screen_height / gre_pkg::GLYPH_ROWS) +
                                   int'($urandom_range(0, 2)) - 1);
      end
      send_item(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (glyph_rows_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Junk above the register width is dropped by the block
   task automatic write_register(input logic [gre_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [63:0] value, input int width, input bit junk);
      logic [gre_pkg::ADDR_W-1:0] keep;
      logic [gre_pkg::ADDR_W-1:0] data;
      keep = (gre_pkg::ADDR_W'(1) << width) - gre_pkg::ADDR_W'(1);
      data = junk ? gre_pkg::ADDR_W'({$urandom, $urandom}) : '0;
      data = (data & ~keep) | (value[gre_pkg::ADDR_W-1:0] & keep);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         gre_pkg::CSR_FRAME_BASE:     cfg_frame_base     = data;
         gre_pkg::CSR_SCREEN_WIDTH:   cfg_screen_width   = data[gre_pkg::SCREEN_W-1:0];
         gre_pkg::CSR_SCREEN_HEIGHT:  cfg_screen_height  = data[gre_pkg::SCREEN_W-1:0];
         gre_pkg::CSR_LINE_PITCH:     cfg_line_pitch     = data[gre_pkg::PITCH_W-1:0];
         gre_pkg::CSR_BITS_PER_PIXEL: cfg_bits_per_pixel = data[gre_pkg::BPP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [gre_pkg::ADDR_W-1:0] base, input int width,
                             input int height, input int pitch, input int depth,
                             input bit junk);
      write_register(gre_pkg::CSR_FRAME_BASE, 64'(base), gre_pkg::ADDR_W, junk);
      write_register(gre_pkg::CSR_SCREEN_WIDTH, 64'(width), gre_pkg::SCREEN_W, junk);
      write_register(gre_pkg::CSR_SCREEN_HEIGHT, 64'(height), gre_pkg::SCREEN_W, junk);
      write_register(gre_pkg::CSR_LINE_PITCH, 64'(pitch), gre_pkg::PITCH_W, junk);
      write_register(gre_pkg::CSR_BITS_PER_PIXEL, 64'(depth), gre_pkg::BPP_W, junk);
      csr_wr_en <= 1'b0;
   endtask

   // Registers at reset: zero screen clips every pixel, zero pitch and base
   task automatic test_reset_defaults();
      load_glyph(8'h00, 1'b1);
      load_glyph(8'hFF, 1'b1);
      draw_at(8'h00, 0, 0, 32'h00FF_00FF, 32'hFF00_FF00);
      draw_at(8'hFF, 5, 7, 32'hFFFF_FFFF, 32'h0000_0000);
      drain();
   endtask

   task automatic test_clipping_and_depth();
      set_config(48'h1000, 100, 50, 2560, 32, 1'b0);
      draw_at(8'h00, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
      draw_at(8'hFF, 12, 0, 32'h0000_0000, 32'hFFFF_FFFF);   // right edge cuts the cell
      draw_at(8'h00, 1, 3, 32'h1234_5678, 32'h9ABC_DEF0);    // bottom edge cuts the cell
      draw_at(8'hFF, 1023, 511, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      drain();
      set_config('1, 8191, 8191, 65535, 32, 1'b0);
      draw_at(8'hFF, 1023, 511, 32'hFFFF_FFFF, 32'h0000_0000);  // address wraps
      draw_at(8'h00, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
      drain();
      set_config(48'h0, 8191, 8191, 0, 16, 1'b0);
      draw_at(8'h00, 0, 0, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      drain();
      set_config(48'h8000_0000_0000, 8191, 8191, 1, 0, 1'b0);
      draw_at(8'hFF, 3, 2, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      drain();
      set_config(48'h0, 8191, 8191, 4, 63, 1'b0);
      draw_at(8'h00, 7, 9, 32'h8000_0001, 32'h7FFF_FFFE);
      drain();
      set_config(48'h00AB_CDEF_0123, 640, 480, 2560, 32, 1'b1);
      draw_at(8'hFF, 79, 29, 32'hCAFE_F00D, 32'h1357_9BDF);
      drain();
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      int          sent;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            set_config('1, 8191, 8191, 65535, 32, 1'b0);
            sink_mode = SINK_OPEN;
            gaps_on   = 1'b0;
         end else begin
            set_config(gre_pkg::ADDR_W'({$urandom, $urandom}),
                       ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 200),
                       ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 200),
                       $urandom_range(0, 65535),
                       ($urandom_range(0, 9) < 7) ? 32 : $urandom_range(0, 63),
                       $urandom_range(0, 1) == 1);
            sink_mode = (phase == 2) ? SINK_BURSTY : SINK_CHOPPY;
            gaps_on   = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (ready_glyphs.size() < 3 || pick < 4) begin
               load_glyph(gre_pkg::CODE_IN_W'($urandom), 1'b0);
               sent += gre_pkg::GLYPH_ROWS;
            end else if (pick < 12) begin
               // stray row: partial glyph or overwrite of a loaded one
               send_item(noisy_request() & ~{1'b1, {($bits(glyph_req_type)-1){1'b0}}});
               sent++;
            end else begin
               draw_random();
               sent++;
            end
         end
         drain();
      end
   endtask

   // Hold the result side off while draws keep coming, so the input backs up
   task automatic test_back_pressure();
      sink_mode        = SINK_OPEN;
      gaps_on          = 1'b0;
      hold_off_pending = 1'b1;
      repeat (8) draw_random();
      drain();
      sink_mode = SINK_CHOPPY;
      gaps_on   = 1'b1;
   endtask

   initial begin : result_sink
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            case (sink_mode)
               SINK_OPEN: begin
                  rsp_stall <= 1'b0;
                  @(posedge clock);
               end
               SINK_CHOPPY: begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
                  @(posedge clock);
               end
               default: begin
                  rsp_stall <= ~rsp_stall;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : row_check
      glyph_row_type                                        want;
      logic [gre_pkg::GLYPH_COLS-1:0][gre_pkg::COLOR_W-1:0] got_pix;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got_pix = {rsp_pixel_7, rsp_pixel_6, rsp_pixel_5, rsp_pixel_4,
                    rsp_pixel_3, rsp_pixel_2, rsp_pixel_1, rsp_pixel_0};
         if (glyph_rows_due.size() == 0) begin
            report_mismatch("unexpected row transaction", rows_seen, 64'(rsp_row_address), '0);
         end else begin
            want = glyph_rows_due.pop_front();
            if (rsp_row_address !== want.addr)
               report_mismatch("row_address", rows_seen, 64'(rsp_row_address), 64'(want.addr));
            if (rsp_write_mask !== want.mask)
               report_mismatch("write_mask", rows_seen, 64'(rsp_write_mask), 64'(want.mask));
            for (int j = 0; j < gre_pkg::GLYPH_COLS; j++) begin
               if (got_pix[j] !== want.pix[j])
                  report_mismatch($sformatf("pixel_%0d", j), rows_seen, 64'(got_pix[j]),
                                  64'(want.pix[j]));
            end
            if (rsp_last_row !== want.last)
               report_mismatch("last_row", rows_seen, 64'(rsp_last_row), 64'(want.last));
         end
         rows_seen++;
      end
   end

   initial begin : watchdog
      int unsigned still_cycles;
      still_cycles = 0;
      while (still_cycles < STILL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
             csr_wr_en)
            still_cycles = 0;
         else
            still_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : run_tests
      for (int g = 0; g < gre_pkg::GLYPH_COUNT; g++) begin
         rows_loaded[g] = '0;
         glyph_ready[g] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_clipping_and_depth();
      test_random_traffic();
      test_back_pressure();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_fields == 0 && glyph_rows_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== glyph_row_expander_core.f =====
hw/rtl/gre_pkg.sv
hw/rtl/glyph_row_expander_core.sv
tb/sv/tb_glyph_row_expander_core.sv
